>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the sieve and totient engine.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/spfte_pkg.sv
// Shared types and constants of the smallest-prime-factor sieve and totient engine.
// Depends on nothing; imported by every module of the block.
package spfte_pkg;

   localparam int unsigned DEF_TABLE_DEPTH = 65536;
   localparam int unsigned DATA_W          = 16;

   localparam logic OP_BUILD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [15:0] SIEVE_LIMIT_RST = 16'hFFFF;

   typedef enum logic [1:0] {
      RSP_OK        = 2'd0,
      RSP_BUILT     = 2'd1,
      RSP_NOT_BUILT = 2'd2,
      RSP_BAD_VALUE = 2'd3
   } spfte_rsp_type;

   typedef struct packed {
      logic          build_start;
      logic          fill_wr;
      logic          p_rd;
      logic          p_next;
      logic          k_init;
      logic          k_rd;
      logic          k_wr;
      logic          q_start;
      logic          q_rd;
      logic          q_look;
      logic          q_div;
      logic          q_upd;
      logic          emit;
      spfte_rsp_type code;
   } spfte_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic sq_over;
      logic p_prime;
      logic k_over;
      logic mm_low;
      logic pr_low;
      logic div_done;
      logic value_bad;
      logic ready;
   } spfte_stat_type;

endpackage

>>> src/spfte_div.sv
// Restoring divider, one quotient bit per cycle, for the totient factoring loop.
// Depends on spfte_pkg for the data width.
module spfte_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [spfte_pkg::DATA_W-1:0]   dividend,
   input  logic [spfte_pkg::DATA_W-1:0]   divisor,
   output logic                           done,
   output logic [spfte_pkg::DATA_W-1:0]   quotient
);
   import spfte_pkg::*;

   localparam int unsigned CW = $clog2(DATA_W + 1);

   logic              run_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] div_ff;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[DATA_W-1]};
      diff  = trial - {1'b0, div_ff};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = diff[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(DATA_W);
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/spfte_dp.sv
// Datapath: factor table memory, sieve counters, totient registers and result word.
// Depends on spfte_pkg and spfte_div.
module spfte_dp #(
   parameter int unsigned TABLE_DEPTH = spfte_pkg::DEF_TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spfte_pkg::spfte_cmd_type    cmd,
   input  logic [15:0]                 sieve_limit,
   input  logic [15:0]                 query_value,
   output spfte_pkg::spfte_stat_type   stat,
   output logic                        rsp_strobe,
   output logic [15:0]                 rsp_totient_value,
   output logic [15:0]                 rsp_least_factor,
   output logic [1:0]                  rsp_status
);
   import spfte_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam logic [15:0] LIM_MAX =
      (TABLE_DEPTH - 1 > 65535) ? 16'hFFFF : 16'(TABLE_DEPTH - 1);

   logic [15:0] factor_mem [TABLE_DEPTH];
   logic [15:0] rd_ff;
   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [15:0] mem_wd;

   logic        ready_ff;
   logic [15:0] lim_ff, lim_in;
   logic [15:0] cnt_ff;
   logic [8:0]  p_ff;
   logic [16:0] sq_ff;
   logic [16:0] k_ff;

   logic [15:0] mm_ff, ph_ff, pr_ff, prev_ff, fac_ff, lf_ff;
   logic        first_ff;
   logic [15:0] prod;
   logic [15:0] lf_now;
   logic        div_done;
   logic [15:0] quot;

   logic        strobe_ff;
   logic [15:0] tot_ff, least_ff;
   logic [1:0]  status_ff;

   spfte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.q_div),
      .dividend (mm_ff),
      .divisor  (rd_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign lim_in = (sieve_limit > LIM_MAX) ? LIM_MAX : sieve_limit;
   assign prod   = ph_ff * fac_ff;
   assign lf_now = first_ff ? rd_ff : lf_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = AW'(cnt_ff);
      mem_wd = cnt_ff;
      if (cmd.fill_wr) begin
         mem_we = 1'b1;
      end else if (cmd.k_wr) begin
         mem_we = ({1'b0, rd_ff} == k_ff);
         mem_wa = AW'(k_ff);
         mem_wd = 16'(p_ff);
      end
   end

   always_comb begin
      mem_ra = AW'(mm_ff);
      if (cmd.p_rd) begin
         mem_ra = AW'(p_ff);
      end else if (cmd.k_rd) begin
         mem_ra = AW'(k_ff);
      end else if (cmd.q_rd) begin
         mem_ra = AW'(mm_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         factor_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= factor_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         lim_ff    <= '0;
         first_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
         if (cmd.build_start) begin
            lim_ff <= lim_in;
         end
         if (cmd.emit && cmd.code == RSP_BUILT) begin
            ready_ff <= 1'b1;
         end
         if (cmd.q_start) begin
            first_ff <= 1'b1;
         end else if (cmd.q_look) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_start) begin
         cnt_ff <= '0;
         p_ff   <= 9'd2;
         sq_ff  <= 17'd4;
      end else begin
         if (cmd.fill_wr) begin
            cnt_ff <= cnt_ff + 16'd1;
         end
         if (cmd.p_next) begin
            p_ff  <= p_ff + 9'd1;
            sq_ff <= sq_ff + 17'({p_ff, 1'b1});
         end
      end
      if (cmd.k_init) begin
         k_ff <= sq_ff;
      end else if (cmd.k_wr) begin
         k_ff <= k_ff + 17'(p_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         mm_ff   <= query_value;
         ph_ff   <= 16'd1;
         prev_ff <= '0;
      end else if (cmd.q_upd) begin
         mm_ff   <= quot;
         ph_ff   <= prod;
         prev_ff <= pr_ff;
      end
      if (cmd.q_look && first_ff) begin
         lf_ff <= rd_ff;
      end
      if (cmd.q_div) begin
         pr_ff  <= rd_ff;
         fac_ff <= (rd_ff == prev_ff) ? rd_ff : rd_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         status_ff <= cmd.code;
         if (cmd.code == RSP_OK) begin
            tot_ff   <= ph_ff;
            least_ff <= lf_now;
         end else begin
            tot_ff   <= '0;
            least_ff <= '0;
         end
      end
   end

   always_comb begin
      stat.fill_last = (cnt_ff == lim_ff);
      stat.sq_over   = (sq_ff > {1'b0, lim_ff});
      stat.p_prime   = (rd_ff == 16'(p_ff));
      stat.k_over    = (k_ff > {1'b0, lim_ff});
      stat.mm_low    = (mm_ff <= 16'd1);
      stat.pr_low    = (rd_ff < 16'd2);
      stat.div_done  = div_done;
      stat.value_bad = (query_value == 16'd0) || (query_value > lim_ff);
      stat.ready     = ready_ff;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_totient_value = tot_ff;
   assign rsp_least_factor  = least_ff;
   assign rsp_status        = status_ff;

endmodule

>>> src/spfte_ctrl.sv
// Controller: sequences table fill, sieve passes and the totient factoring loop.
// Depends on spfte_pkg; drives spfte_dp through command and status structs.
module spfte_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        opcode,
   input  spfte_pkg::spfte_stat_type   stat,
   output spfte_pkg::spfte_cmd_type    cmd,
   output logic                        busy
);
   import spfte_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_P_TEST,
      S_P_CHK,
      S_K_TEST,
      S_K_WR,
      S_Q_RD,
      S_Q_TAKE,
      S_Q_DIV,
      S_Q_UPD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      cmd.code = RSP_OK;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (opcode == OP_BUILD) begin
                  cmd.build_start = 1'b1;
                  state_in        = S_FILL;
               end else if (!stat.ready) begin
                  cmd.emit = 1'b1;
                  cmd.code = RSP_NOT_BUILT;
               end else if (stat.value_bad) begin
                  cmd.emit = 1'b1;
                  cmd.code = RSP_BAD_VALUE;
               end else begin
                  cmd.q_start = 1'b1;
                  state_in    = S_Q_RD;
               end
            end
         end
         S_FILL: begin
            cmd.fill_wr = 1'b1;
            if (stat.fill_last) begin
               state_in = S_P_TEST;
            end
         end
         S_P_TEST: begin
            if (stat.sq_over) begin
               cmd.emit = 1'b1;
               cmd.code = RSP_BUILT;
               state_in = S_IDLE;
            end else begin
               cmd.p_rd = 1'b1;
               state_in = S_P_CHK;
            end
         end
         S_P_CHK: begin
            if (stat.p_prime) begin
               cmd.k_init = 1'b1;
               state_in   = S_K_TEST;
            end else begin
               cmd.p_next = 1'b1;
               state_in   = S_P_TEST;
            end
         end
         S_K_TEST: begin
            if (stat.k_over) begin
               cmd.p_next = 1'b1;
               state_in   = S_P_TEST;
            end else begin
               cmd.k_rd = 1'b1;
               state_in = S_K_WR;
            end
         end
         S_K_WR: begin
            cmd.k_wr = 1'b1;
            state_in = S_K_TEST;
         end
         S_Q_RD: begin
            cmd.q_rd = 1'b1;
            state_in = S_Q_TAKE;
         end
         S_Q_TAKE: begin
            cmd.q_look = 1'b1;
            if (stat.mm_low || stat.pr_low) begin
               cmd.emit = 1'b1;
               cmd.code = RSP_OK;
               state_in = S_IDLE;
            end else begin
               cmd.q_div = 1'b1;
               state_in  = S_Q_DIV;
            end
         end
         S_Q_DIV: begin
            if (stat.div_done) begin
               state_in = S_Q_UPD;
            end
         end
         S_Q_UPD: begin
            cmd.q_upd = 1'b1;
            state_in  = S_Q_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> src/spf_sieve_totient_engine.sv
// Top level of the smallest-prime-factor sieve and Euler totient engine.
// Depends on spfte_pkg, spfte_ctrl, spfte_dp and assert_macros.svh.
//
//   channel   handshake                         payload
//   request   start / busy                      req_opcode, req_query_value
//   response  rsp_strobe (one cycle, no stall)  rsp_totient_value, rsp_least_factor,
//                                               rsp_status
//   csr       psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// Rejected query (not built, zero, above limit): word on rsp the cycle after start.
// Query: each prime factor of m, counted with multiplicity, costs a read, a lookup, a
// division and an update; the word goes on rsp once m is reduced to 1.
// Build: fills 0..L, then a test and a check per candidate p with p * p <= L, a further
// test per prime, a read and write per multiple, a final test; rsp word the cycle after.
// Reset clears control state only, the table is undefined until a build; rsp never stalls.
`include "assert_macros.svh"

module spf_sieve_totient_engine #(
   parameter int unsigned TABLE_DEPTH = spfte_pkg::DEF_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [15:0] req_query_value,
   output logic        rsp_strobe,
   output logic [15:0] rsp_totient_value,
   output logic [15:0] rsp_least_factor,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import spfte_pkg::*;

   spfte_cmd_type  cmd;
   spfte_stat_type stat;
   logic [15:0]    sieve_limit_ff;
   logic           build_take;
   logic           unbuilt_take;
   logic           rsp_unbuilt;
   logic           rsp_err;
   logic           rsp_good;
   logic           rsp_zero;
   logic           rsp_nonzero;

   always_ff @(posedge clock) begin
      if (reset) begin
         sieve_limit_ff <= SIEVE_LIMIT_RST;
      end else if (psel && penable && pwrite) begin
         sieve_limit_ff <= pwdata[15:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = {16'd0, sieve_limit_ff};

   spfte_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   spfte_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sieve_limit       (sieve_limit_ff),
      .query_value       (req_query_value),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_totient_value (rsp_totient_value),
      .rsp_least_factor  (rsp_least_factor),
      .rsp_status        (rsp_status)
   );

   assign build_take   = start && !busy && (req_opcode == OP_BUILD);
   assign unbuilt_take = start && !busy && (req_opcode == OP_QUERY) && !stat.ready;
   assign rsp_unbuilt  = rsp_strobe && (rsp_status == RSP_NOT_BUILT);
   assign rsp_err      = rsp_strobe && (rsp_status != RSP_OK);
   assign rsp_good     = rsp_strobe && (rsp_status == RSP_OK);
   assign rsp_zero     = (rsp_totient_value == 16'd0) && (rsp_least_factor == 16'd0);
   assign rsp_nonzero  = (rsp_totient_value != 16'd0) && (rsp_least_factor != 16'd0);

   `ASSERT_NEXT(a_build_goes_busy, clock, reset, build_take, busy)
   `ASSERT_NEXT(a_unbuilt_rejected, clock, reset, unbuilt_take, rsp_unbuilt)
   `ASSERT_IMPLIES(a_error_fields_zero, clock, reset, rsp_err, rsp_zero)
   `ASSERT_IMPLIES(a_ok_fields_nonzero, clock, reset, rsp_good, rsp_nonzero)

endmodule
